[src/sps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the sequence pattern search
// Capacity of the pattern, command codes and the control word that is
// broadcast along the chain of compare cells.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int MaxPattern = 64;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int SymW       = 8;
  localparam int CmdW       = 2;
  localparam int CountW     = 7;

  typedef enum logic [CmdW-1:0] {
    CmdStart  = 2'd0,
    CmdAppend = 2'd1,
    CmdText   = 2'd2
  } sps_cmd_e;

  typedef struct packed {
    logic            start;
    logic            append;
    logic            text;
    logic [SymW-1:0] symbol;
  } sps_ctrl_t;

endpackage

[src/sps_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_if: channel interfaces of the sequence pattern search
// A valid/ready handshake with the input item and the result item payloads.
// ----------------------------------------------------------------------------
interface sps_in_if;
  logic                     valid;
  logic                     ready;
  logic [sps_pkg::CmdW-1:0] cmd;
  logic [sps_pkg::SymW-1:0] symbol;
  logic                     last;

  modport source (output valid, cmd, symbol, last, input ready);
  modport sink   (input valid, cmd, symbol, last, output ready);
endinterface

interface sps_out_if;
  logic                       valid;
  logic                       ready;
  logic                       match_here;
  logic                       found;
  logic                       pattern_overflow;
  logic                       done_res;
  logic [sps_pkg::CountW-1:0] pattern_count;

  modport source (output valid, match_here, found, pattern_overflow, done_res,
                  pattern_count, input ready);
  modport sink   (input valid, match_here, found, pattern_overflow, done_res,
                  pattern_count, output ready);
endinterface

[src/sequence_pattern_search_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_pattern_search_top: exact pattern search over a symbol stream
// Loads a pattern symbol by symbol into a chain of compare cells and reports
// for every text symbol whether it completes an occurrence of the pattern.
// ----------------------------------------------------------------------------
//  Channel | Direction | Transaction payload
//  in_i    | sink      | cmd, symbol, last
//  out_o   | source    | match_here, found, pattern_overflow, done_res,
//          |           | pattern_count
//
// In each input transaction every cell compares its symbol in parallel, and
// the result is held in the output register the next cycle.
// A new transaction is taken whenever the output register is empty or drained
// in the same cycle, so one item per cycle is sustained while out_o is ready.
// Reset clears the pattern length, the flags and every cell's occupied bit.
// A stall on out_o holds the result and stops input after one item.
// ----------------------------------------------------------------------------
module sequence_pattern_search_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  sps_in_if.sink     in_i,
  sps_out_if.source  out_o
);

  logic                        accept;
  sps_pkg::sps_ctrl_t          ctrl;
  logic                        is_append;
  logic                        hit;
  logic [sps_pkg::LenW-1:0]    len_q, len_d;
  logic                        found_q, found_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q;
  logic                        match_q;
  logic                        done_q;
  logic [sps_pkg::LenW+sps_pkg::CountW-1:0] len_wide;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    ctrl        = '0;
    is_append   = 1'b0;
    ctrl.symbol = in_i.symbol;
    case (sps_pkg::sps_cmd_e'(in_i.cmd))
      sps_pkg::CmdStart:  ctrl.start = accept;
      sps_pkg::CmdAppend: is_append  = accept;
      sps_pkg::CmdText:   ctrl.text  = accept;
      default: ;
    endcase
    // An append beyond capacity never reaches the cells.
    ctrl.append = is_append && (len_q < sps_pkg::LenW'(sps_pkg::MaxPattern));
  end

  always_comb begin
    len_d       = len_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    if (ctrl.start) begin
      len_d   = '0;
      found_d = 1'b0;
      ovf_d   = 1'b0;
    end else if (is_append) begin
      if (ctrl.append) begin
        len_d       = len_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end else if (hit) begin
      found_d = 1'b1;
    end
  end

  sps_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .hit_o (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      match_q <= hit;
      done_q  <= ctrl.text && in_i.last;
    end
  end

  // The count fits the width of the result field and is reported in full.
  assign len_wide = {{sps_pkg::CountW{1'b0}}, len_q};

  assign out_o.valid            = out_valid_q;
  assign out_o.match_here       = match_q;
  assign out_o.found            = found_q;
  assign out_o.pattern_overflow = ovf_q;
  assign out_o.done_res         = done_q;
  assign out_o.pattern_count    = len_wide[sps_pkg::CountW-1:0];

endmodule

[src/sps_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_cell: one pattern position of the compare chain
// Holds one pattern symbol, an occupied flag and the prefix match bit, and
// updates the bit from the bit of its left neighbour on each text symbol.
// ----------------------------------------------------------------------------
module sps_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sps_pkg::sps_ctrl_t ctrl_i,
  input  logic               prev_bit_i,
  input  logic               prev_valid_i,
  input  logic               next_valid_i,
  output logic               bit_o,
  output logic               valid_o,
  output logic               hit_o
);

  logic                     valid_q, valid_d;
  logic                     bit_q, bit_d;
  logic [sps_pkg::SymW-1:0] sym_q;
  logic                     take;
  logic                     cmp_bit;

  // The first free cell is the one whose left neighbour is occupied.
  assign take    = ctrl_i.append && prev_valid_i && !valid_q;
  assign cmp_bit = prev_bit_i && (sym_q == ctrl_i.symbol);

  always_comb begin
    valid_d = valid_q;
    bit_d   = bit_q;
    if (ctrl_i.start) begin
      valid_d = 1'b0;
      bit_d   = 1'b0;
    end else if (take) begin
      valid_d = 1'b1;
      bit_d   = 1'b0;
    end else if (ctrl_i.text && valid_q) begin
      bit_d = cmp_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      bit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sym_q <= ctrl_i.symbol;
    end
  end

  // Only the highest occupied cell reports a complete occurrence.
  assign hit_o   = ctrl_i.text && valid_q && !next_valid_i && cmp_bit;
  assign bit_o   = bit_q;
  assign valid_o = valid_q;

endmodule

[src/sps_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_chain: row of compare cells
// Links the cells to their neighbours and gathers the match of the highest
// occupied cell.
// ----------------------------------------------------------------------------
module sps_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sps_pkg::sps_ctrl_t ctrl_i,
  output logic               hit_o
);

  localparam int N = sps_pkg::MaxPattern;

  logic [N-1:0] bit_vec;
  logic [N-1:0] valid_vec;
  logic [N-1:0] hit_vec;
  logic [N:0]   prev_bit;
  logic [N:0]   prev_valid;
  logic [N:0]   next_valid;

  // Position zero always has an empty, matching prefix to its left.
  assign prev_bit   = {bit_vec, 1'b1};
  assign prev_valid = {valid_vec, 1'b1};
  assign next_valid = {1'b0, valid_vec};

  for (genvar k = 0; k < N; k++) begin : g_cell
    sps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .prev_bit_i  (prev_bit[k]),
      .prev_valid_i(prev_valid[k]),
      .next_valid_i(next_valid[k+1]),
      .bit_o       (bit_vec[k]),
      .valid_o     (valid_vec[k]),
      .hit_o       (hit_vec[k])
    );
  end

  assign hit_o = |hit_vec;

endmodule
